// ===== hw/rtl/one_wire_bus_master_top_defines.svh =====
// Assertion helpers for the one-wire bus master.
`ifndef ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Immediate-cycle implication, disabled while reset is held.
`define OWBM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("owbm assertion failed");
// Condition in this cycle implies the expectation in the next one.
`define OWBM_ASSERT_NEXT(lbl, clk, rst_n, cond, expct) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
        else $error("owbm next-cycle assertion failed");
`else
`define OWBM_ASSERT(lbl, clk, rst_n, prop)
`define OWBM_ASSERT_NEXT(lbl, clk, rst_n, cond, expct)
`endif

`endif

// ===== hw/rtl/owbm_pkg.sv =====
package owbm_pkg;

    localparam int CFG_W     = 16;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 16'd550;
    localparam logic [CFG_W-1:0] RELEASE_WAIT_DEF  = 16'd40;
    localparam logic [CFG_W-1:0] PRESENCE_HOLD_DEF = 16'd240;
    localparam logic [CFG_W-1:0] WRITE_SLOT_DEF    = 16'd40;
    localparam logic [CFG_W-1:0] READ_SLOT_DEF     = 16'd70;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_RELEASE_WAIT  = 3'd1,
        CFG_PRESENCE_HOLD = 3'd2,
        CFG_WRITE_SLOT    = 3'd3,
        CFG_READ_SLOT     = 3'd4
    } t_cfg_idx;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_RST_LOW   = 12'b0000_0000_0010,
        PH_RST_REL   = 12'b0000_0000_0100,
        PH_RST_WAIT  = 12'b0000_0000_1000,
        PH_RST_HOLD  = 12'b0000_0001_0000,
        PH_WR_START  = 12'b0000_0010_0000,
        PH_WR_LEVEL  = 12'b0000_0100_0000,
        PH_WR_REC    = 12'b0000_1000_0000,
        PH_RD_START  = 12'b0001_0000_0000,
        PH_RD_REL    = 12'b0010_0000_0000,
        PH_RD_SAMPLE = 12'b0100_0000_0000,
        PH_RD_SLOT   = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] release_wait_ticks;
        logic [CFG_W-1:0] presence_hold_ticks;
        logic [CFG_W-1:0] write_slot_ticks;
        logic [CFG_W-1:0] read_slot_ticks;
    } t_cfg;

    typedef struct packed {
        t_op        op;
        logic       is_cmd;
        logic [7:0] data_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qlink;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       refused;
    } t_res;

    // Last tick of a timed phase: zero length counts as one tick, long
    // lengths clamp to the counter range.
    function automatic logic at_limit(logic [CNT_W-1:0] cnt, logic [CFG_W-1:0] len);
        logic [CFG_W-1:0]       lim;
        logic [CNT_W+CFG_W-1:0] lim_w;
        logic [CNT_W+CFG_W-1:0] cnt_w;
        logic [CNT_W+CFG_W-1:0] mask_w;
        lim    = (len == '0) ? '0 : len - 1'b1;
        lim_w  = {{CNT_W{1'b0}}, lim};
        cnt_w  = {{CFG_W{1'b0}}, cnt};
        mask_w = {{CFG_W{1'b0}}, {CNT_W{1'b1}}};
        if (lim_w > mask_w) begin
            lim_w = mask_w;
        end
        return cnt_w >= lim_w;
    endfunction

endpackage

// ===== hw/rtl/owbm_ifs.sv =====
interface owbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       line_level;
    modport source (output valid, op, data_byte, line_level, input ready);
    modport sink   (input valid, op, data_byte, line_level, output ready);
endinterface

interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       refused;
    modport source (output valid, drive_low, busy_res, done_res, read_value, refused,
                    input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, read_value, refused,
                    output ready);
endinterface

interface owbm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [owbm_pkg::CFG_IDX_W-1:0]  index;
    logic [owbm_pkg::CFG_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/owbm_front.sv =====
module owbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    owbm_cmd_if.sink          i_cmd,
    output owbm_pkg::t_qlink  o_q,
    input  logic              i_q_ready
);

    logic            r_valid;
    owbm_pkg::t_item r_item;
    owbm_pkg::t_item w_class;
    logic            w_accept;

    assign i_cmd.ready = !r_valid || i_q_ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_comb begin
        w_class.op         = owbm_pkg::t_op'(i_cmd.op);
        w_class.is_cmd     = (owbm_pkg::t_op'(i_cmd.op) != owbm_pkg::OP_TICK);
        w_class.data_byte  = i_cmd.data_byte;
        w_class.line_level = i_cmd.line_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_class;
        end
    end

    assign o_q.valid = r_valid;
    assign o_q.item  = r_item;

endmodule

// ===== hw/rtl/owbm_queue.sv =====
`include "one_wire_bus_master_top_defines.svh"

module owbm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  owbm_pkg::t_qlink  i_q,
    output logic              o_q_ready,
    output owbm_pkg::t_qlink  o_q,
    input  logic              i_pop_ready
);

    owbm_pkg::t_item                r_mem [owbm_pkg::Q_DEPTH];
    logic [owbm_pkg::Q_PTR_W-1:0]   r_wr;
    logic [owbm_pkg::Q_PTR_W-1:0]   r_rd;
    logic [owbm_pkg::Q_CNT_W-1:0]   r_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_q_ready = (r_count != owbm_pkg::Q_CNT_W'(owbm_pkg::Q_DEPTH));
    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_mem[r_rd];
    assign w_push    = i_q.valid && o_q_ready;
    assign w_pop     = o_q.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == owbm_pkg::Q_PTR_W'(owbm_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == owbm_pkg::Q_PTR_W'(owbm_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_q.item;
        end
    end

    `OWBM_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= owbm_pkg::Q_CNT_W'(owbm_pkg::Q_DEPTH))
    `OWBM_ASSERT(a_no_push_full, i_clk, i_rst_n, !o_q_ready |-> !w_push)
    `OWBM_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

// ===== hw/rtl/owbm_engine.sv =====
`include "one_wire_bus_master_top_defines.svh"

module owbm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  owbm_pkg::t_cfg    i_cfg,
    input  owbm_pkg::t_qlink  i_q,
    output logic              o_pop_ready,
    owbm_res_if.source        o_res
);

    owbm_pkg::t_phase             r_phase, n_phase, w_phase;
    logic [2:0]                   r_bit, n_bit, w_bit;
    logic [owbm_pkg::CNT_W-1:0]   r_cnt, n_cnt, w_cnt;
    logic [7:0]                   r_shift, n_shift, w_shift;
    logic [7:0]                   r_last, n_last;
    logic                         r_out_valid;
    owbm_pkg::t_res               r_out, n_res;
    logic                         w_pop;
    logic                         w_drive, w_done, w_refused;
    owbm_pkg::t_item              w_item;

    assign w_item      = i_q.item;
    assign o_pop_ready = !r_out_valid || o_res.ready;
    assign w_pop       = i_q.valid && o_pop_ready;

    always_comb begin
        w_phase   = r_phase;
        w_bit     = r_bit;
        w_cnt     = r_cnt;
        w_shift   = r_shift;
        w_refused = 1'b0;
        // command start: the same item is the command's first tick
        if (w_item.is_cmd) begin
            if (r_phase == owbm_pkg::PH_IDLE) begin
                w_bit = '0;
                w_cnt = '0;
                unique case (w_item.op)
                    owbm_pkg::OP_RESET: begin
                        w_phase = owbm_pkg::PH_RST_LOW;
                    end
                    owbm_pkg::OP_WRITE: begin
                        w_shift = w_item.data_byte;
                        w_phase = owbm_pkg::PH_WR_START;
                    end
                    default: begin
                        w_shift = '0;
                        w_phase = owbm_pkg::PH_RD_START;
                    end
                endcase
            end else begin
                w_refused = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase = w_phase;
        n_bit   = w_bit;
        n_cnt   = w_cnt;
        n_shift = w_shift;
        n_last  = r_last;
        w_drive = 1'b0;
        w_done  = 1'b0;
        unique case (w_phase)
            owbm_pkg::PH_IDLE: begin
            end
            owbm_pkg::PH_RST_LOW: begin
                w_drive = 1'b1;
                if (owbm_pkg::at_limit(w_cnt, i_cfg.reset_low_ticks)) begin
                    n_cnt   = '0;
                    n_phase = owbm_pkg::PH_RST_REL;
                end else begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
            owbm_pkg::PH_RST_REL: begin
                if (owbm_pkg::at_limit(w_cnt, i_cfg.release_wait_ticks)) begin
                    n_cnt   = '0;
                    n_phase = owbm_pkg::PH_RST_WAIT;
                end else begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
            owbm_pkg::PH_RST_WAIT: begin
                if (!w_item.line_level) begin
                    n_cnt   = '0;
                    n_phase = owbm_pkg::PH_RST_HOLD;
                end
            end
            owbm_pkg::PH_RST_HOLD: begin
                if (owbm_pkg::at_limit(w_cnt, i_cfg.presence_hold_ticks)) begin
                    n_cnt   = '0;
                    n_phase = owbm_pkg::PH_IDLE;
                    w_done  = 1'b1;
                end else begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
            owbm_pkg::PH_WR_START: begin
                w_drive = 1'b1;
                n_cnt   = '0;
                n_phase = owbm_pkg::PH_WR_LEVEL;
            end
            owbm_pkg::PH_WR_LEVEL: begin
                w_drive = !w_shift[w_bit];
                if (owbm_pkg::at_limit(w_cnt, i_cfg.write_slot_ticks)) begin
                    n_cnt   = '0;
                    n_phase = owbm_pkg::PH_WR_REC;
                end else begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
            owbm_pkg::PH_WR_REC: begin
                if (w_bit == 3'd7) begin
                    n_cnt   = '0;
                    n_phase = owbm_pkg::PH_IDLE;
                    w_done  = 1'b1;
                end else begin
                    n_bit   = w_bit + 1'b1;
                    n_phase = owbm_pkg::PH_WR_START;
                end
            end
            owbm_pkg::PH_RD_START: begin
                w_drive = 1'b1;
                n_phase = owbm_pkg::PH_RD_REL;
            end
            owbm_pkg::PH_RD_REL: begin
                n_phase = owbm_pkg::PH_RD_SAMPLE;
            end
            owbm_pkg::PH_RD_SAMPLE: begin
                if (w_item.line_level) begin
                    n_shift[w_bit] = 1'b1;
                end
                n_cnt   = '0;
                n_phase = owbm_pkg::PH_RD_SLOT;
            end
            owbm_pkg::PH_RD_SLOT: begin
                if (owbm_pkg::at_limit(w_cnt, i_cfg.read_slot_ticks)) begin
                    n_cnt = '0;
                    if (w_bit == 3'd7) begin
                        n_last  = w_shift;
                        n_phase = owbm_pkg::PH_IDLE;
                        w_done  = 1'b1;
                    end else begin
                        n_bit   = w_bit + 1'b1;
                        n_phase = owbm_pkg::PH_RD_START;
                    end
                end else begin
                    n_cnt = w_cnt + 1'b1;
                end
            end
            default: begin
                // stray phase code: back to idle, line released
                n_cnt   = '0;
                n_phase = owbm_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res.drive_low  = w_drive;
        n_res.busy_res   = (n_phase != owbm_pkg::PH_IDLE);
        n_res.done_res   = w_done;
        n_res.read_value = n_last;
        n_res.refused    = w_refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owbm_pkg::PH_IDLE;
            r_bit       <= '0;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_cnt   <= n_cnt;
                r_shift <= n_shift;
                r_last  <= n_last;
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.drive_low  = r_out.drive_low;
    assign o_res.busy_res   = r_out.busy_res;
    assign o_res.done_res   = r_out.done_res;
    assign o_res.read_value = r_out.read_value;
    assign o_res.refused    = r_out.refused;

    `OWBM_ASSERT_NEXT(a_refuse_busy, i_clk, i_rst_n, w_pop && w_item.is_cmd && (r_phase != owbm_pkg::PH_IDLE), r_out.refused)
    `OWBM_ASSERT(a_done_idle, i_clk, i_rst_n, (r_out_valid && r_out.done_res) |-> (r_phase == owbm_pkg::PH_IDLE))
    `OWBM_ASSERT(a_busy_matches, i_clk, i_rst_n, r_out_valid |-> (r_out.busy_res == (r_phase != owbm_pkg::PH_IDLE)))

endmodule

// ===== hw/rtl/one_wire_bus_master_top.sv =====
// Throughput: one item per cycle while the receiver is ready; every item yields
// one result beat. An accepted item passes the front register, then the queue,
// then the sequencer's output register, before its result is presented.
// The queue holds two items, so front and sequencer stall independently.
// Reset (i_rst_n low at a clock edge): sequencer idle, counters and read byte
// cleared, queue empty, tick-length registers back to their defaults.
module one_wire_bus_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owbm_cmd_if.sink    i_cmd,
    owbm_cfg_if.sink    i_cfg,
    owbm_res_if.source  o_res
);

    owbm_pkg::t_cfg   r_cfg;
    owbm_pkg::t_qlink w_front_q;
    owbm_pkg::t_qlink w_back_q;
    logic             w_q_ready;
    logic             w_pop_ready;

    // Configuration writes are always taken; indexes beyond the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= owbm_pkg::RESET_LOW_DEF;
            r_cfg.release_wait_ticks  <= owbm_pkg::RELEASE_WAIT_DEF;
            r_cfg.presence_hold_ticks <= owbm_pkg::PRESENCE_HOLD_DEF;
            r_cfg.write_slot_ticks    <= owbm_pkg::WRITE_SLOT_DEF;
            r_cfg.read_slot_ticks     <= owbm_pkg::READ_SLOT_DEF;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                owbm_pkg::CFG_RESET_LOW:     r_cfg.reset_low_ticks     <= i_cfg.data;
                owbm_pkg::CFG_RELEASE_WAIT:  r_cfg.release_wait_ticks  <= i_cfg.data;
                owbm_pkg::CFG_PRESENCE_HOLD: r_cfg.presence_hold_ticks <= i_cfg.data;
                owbm_pkg::CFG_WRITE_SLOT:    r_cfg.write_slot_ticks    <= i_cfg.data;
                owbm_pkg::CFG_READ_SLOT:     r_cfg.read_slot_ticks     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Front: registers each beat and tags it as tick or command.
    owbm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q       (w_front_q),
        .i_q_ready (w_q_ready)
    );

    // Two-entry queue between front and sequencer.
    owbm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_front_q),
        .o_q_ready   (w_q_ready),
        .o_q         (w_back_q),
        .i_pop_ready (w_pop_ready)
    );

    // Back: bus phase sequencer, one tick per popped beat, registered result.
    owbm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q         (w_back_q),
        .o_pop_ready (w_pop_ready),
        .o_res       (o_res)
    );

endmodule

// ===== sim/one_wire_bus_master_top_tb.sv =====
`timescale 1ns / 1ps

// Tracks the bus master's sequencer tick by tick and holds the result beats it
// should produce, oldest first.
class owbm_line_predictor;
    logic [owbm_pkg::CFG_W-1:0] lens[5];
    owbm_pkg::t_phase           ph;
    logic [2:0]                 bit_idx;
    logic [owbm_pkg::CNT_W-1:0] tick_cnt;
    logic [7:0]                 shift_reg;
    logic [7:0]                 last_byte;
    owbm_pkg::t_res             want_beats[$];
    int                         fails;
    int                         n_items;
    int                         n_started;
    int                         n_refused;
    int                         n_done;
    int                         n_beats;

    function void clear();
        lens[owbm_pkg::CFG_RESET_LOW]     = owbm_pkg::RESET_LOW_DEF;
        lens[owbm_pkg::CFG_RELEASE_WAIT]  = owbm_pkg::RELEASE_WAIT_DEF;
        lens[owbm_pkg::CFG_PRESENCE_HOLD] = owbm_pkg::PRESENCE_HOLD_DEF;
        lens[owbm_pkg::CFG_WRITE_SLOT]    = owbm_pkg::WRITE_SLOT_DEF;
        lens[owbm_pkg::CFG_READ_SLOT]     = owbm_pkg::READ_SLOT_DEF;
        ph        = owbm_pkg::PH_IDLE;
        bit_idx   = '0;
        tick_cnt  = '0;
        shift_reg = '0;
        last_byte = '0;
        want_beats.delete();
        fails     = 0;
        n_items   = 0;
        n_started = 0;
        n_refused = 0;
        n_done    = 0;
        n_beats   = 0;
    endfunction

    // Spare indexes are dropped.
    function void set_reg(logic [owbm_pkg::CFG_IDX_W-1:0] idx, logic [owbm_pkg::CFG_W-1:0] v);
        case (idx)
            owbm_pkg::CFG_RESET_LOW:     lens[owbm_pkg::CFG_RESET_LOW]     = v;
            owbm_pkg::CFG_RELEASE_WAIT:  lens[owbm_pkg::CFG_RELEASE_WAIT]  = v;
            owbm_pkg::CFG_PRESENCE_HOLD: lens[owbm_pkg::CFG_PRESENCE_HOLD] = v;
            owbm_pkg::CFG_WRITE_SLOT:    lens[owbm_pkg::CFG_WRITE_SLOT]    = v;
            owbm_pkg::CFG_READ_SLOT:     lens[owbm_pkg::CFG_READ_SLOT]     = v;
            default: ;
        endcase
    endfunction

    function bit busy();
        return ph != owbm_pkg::PH_IDLE;
    endfunction

    function int pending();
        return want_beats.size();
    endfunction

    // Last tick of a timed phase. Zero length runs as one tick; a 16-bit length
    // never exceeds the counter range, so no clamp is needed here.
    function bit slot_end(logic [owbm_pkg::CFG_W-1:0] len);
        logic [owbm_pkg::CFG_W-1:0] lim;
        lim = (len == '0) ? '0 : len - 1'b1;
        if (tick_cnt >= lim) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = tick_cnt + 1'b1;
        return 1'b0;
    endfunction

    function void wrap_up(ref owbm_pkg::t_res r);
        ph         = owbm_pkg::PH_IDLE;
        tick_cnt   = '0;
        r.done_res = 1'b1;
        n_done++;
    endfunction

    // One accepted input beat: advance by one tick and queue the result.
    function void take_item(owbm_pkg::t_op op, logic [7:0] d, logic line);
        owbm_pkg::t_res r;
        r = '0;
        n_items++;
        if (op != owbm_pkg::OP_TICK) begin
            if (ph == owbm_pkg::PH_IDLE) begin
                bit_idx  = '0;
                tick_cnt = '0;
                n_started++;
                case (op)
                    owbm_pkg::OP_RESET: ph = owbm_pkg::PH_RST_LOW;
                    owbm_pkg::OP_WRITE: begin
                        shift_reg = d;
                        ph        = owbm_pkg::PH_WR_START;
                    end
                    default: begin
                        shift_reg = '0;
                        ph        = owbm_pkg::PH_RD_START;
                    end
                endcase
            end else begin
                // busy: flag it, then treat as a plain tick
                r.refused = 1'b1;
                n_refused++;
            end
        end
        case (ph)
            owbm_pkg::PH_RST_LOW: begin
                r.drive_low = 1'b1;
                if (slot_end(lens[owbm_pkg::CFG_RESET_LOW])) ph = owbm_pkg::PH_RST_REL;
            end
            owbm_pkg::PH_RST_REL: begin
                if (slot_end(lens[owbm_pkg::CFG_RELEASE_WAIT])) ph = owbm_pkg::PH_RST_WAIT;
            end
            owbm_pkg::PH_RST_WAIT: begin
                if (!line) begin
                    tick_cnt = '0;
                    ph       = owbm_pkg::PH_RST_HOLD;
                end
            end
            owbm_pkg::PH_RST_HOLD: begin
                if (slot_end(lens[owbm_pkg::CFG_PRESENCE_HOLD])) wrap_up(r);
            end
            owbm_pkg::PH_WR_START: begin
                r.drive_low = 1'b1;
                tick_cnt    = '0;
                ph          = owbm_pkg::PH_WR_LEVEL;
            end
            owbm_pkg::PH_WR_LEVEL: begin
                r.drive_low = ~shift_reg[bit_idx];
                if (slot_end(lens[owbm_pkg::CFG_WRITE_SLOT])) ph = owbm_pkg::PH_WR_REC;
            end
            owbm_pkg::PH_WR_REC: begin
                if (bit_idx == 3'd7) begin
                    wrap_up(r);
                end else begin
                    bit_idx = bit_idx + 1'b1;
                    ph      = owbm_pkg::PH_WR_START;
                end
            end
            owbm_pkg::PH_RD_START: begin
                r.drive_low = 1'b1;
                ph          = owbm_pkg::PH_RD_REL;
            end
            owbm_pkg::PH_RD_REL: ph = owbm_pkg::PH_RD_SAMPLE;
            owbm_pkg::PH_RD_SAMPLE: begin
                if (line) shift_reg[bit_idx] = 1'b1;
                tick_cnt = '0;
                ph       = owbm_pkg::PH_RD_SLOT;
            end
            owbm_pkg::PH_RD_SLOT: begin
                if (slot_end(lens[owbm_pkg::CFG_READ_SLOT])) begin
                    if (bit_idx == 3'd7) begin
                        last_byte = shift_reg;
                        wrap_up(r);
                    end else begin
                        bit_idx = bit_idx + 1'b1;
                        ph      = owbm_pkg::PH_RD_START;
                    end
                end
            end
            default: ;
        endcase
        r.busy_res   = (ph != owbm_pkg::PH_IDLE);
        r.read_value = last_byte;
        want_beats.push_back(r);
    endfunction

    function void flag(string tag, owbm_pkg::t_res exp, owbm_pkg::t_res act);
        fails++;
        if (fails <= 10) begin
            $display("%s at beat %0d: exp drive=%0b busy=%0b done=%0b read=%02h ref=%0b",
                     tag, n_beats, exp.drive_low, exp.busy_res, exp.done_res,
                     exp.read_value, exp.refused);
            $display("    got drive=%0b busy=%0b done=%0b read=%02h ref=%0b",
                     act.drive_low, act.busy_res, act.done_res, act.read_value,
                     act.refused);
        end
    endfunction

    function void check_beat(owbm_pkg::t_res act);
        owbm_pkg::t_res exp;
        n_beats++;
        if (want_beats.size() == 0) begin
            flag("unexpected result", '0, act);
            return;
        end
        exp = want_beats.pop_front();
        if (act.drive_low !== exp.drive_low || act.busy_res !== exp.busy_res ||
            act.done_res !== exp.done_res || act.read_value !== exp.read_value ||
            act.refused !== exp.refused) begin
            flag("mismatch", exp, act);
        end
    endfunction
endclass

module one_wire_bus_master_top_tb;

    // Generous: about 2000 beats stay well under the limit even with every
    // beat behind a full idle burst and a full stall.
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          SPARE_IDX_LO = 5;
    localparam int          RAND_ROUNDS  = 4;
    localparam int          ROUND_ITEMS  = 80;

    logic i_clk;
    logic i_rst_n;

    owbm_cmd_if cmd_bus ();
    owbm_cfg_if cfg_bus ();
    owbm_res_if res_bus ();

    owbm_line_predictor sb;

    bit          gap_on;      // sender idles in bursts
    bit          stall_on;    // receiver stalls in bursts
    int unsigned cycle_cnt;
    int          n_settings;

    one_wire_bus_master_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hung presence wait or a lost handshake ends up here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, sb.pending());
            $display("FAIL one_wire_bus_master_top");
            $finish;
        end
    end

    // Receiver: ready changes on the falling edge only and drops low in random bursts.
    always begin
        @(negedge i_clk);
        if (stall_on && $urandom_range(0, 9) == 0) begin
            res_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        res_bus.ready <= 1'b1;
    end

    // Every result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        owbm_pkg::t_res act;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            act.drive_low  = res_bus.drive_low;
            act.busy_res   = res_bus.busy_res;
            act.done_res   = res_bus.done_res;
            act.read_value = res_bus.read_value;
            act.refused    = res_bus.refused;
            sb.check_beat(act);
        end
    end

    // odds 0: line always released; odds 1: always low; else low 1 in odds.
    function automatic logic pick_line(int odds);
        if (odds == 0) return 1'b1;
        return $urandom_range(1, odds) != 1;
    endfunction

    // Mostly tiny lengths so random commands finish in a handful of ticks.
    function automatic logic [owbm_pkg::CFG_W-1:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd2;
            default: return owbm_pkg::CFG_W'($urandom_range(3, 10));
        endcase
    endfunction

    // Called on a falling edge; returns on the falling edge after the beat is
    // taken, with valid still high so back-to-back beats stay back to back.
    task automatic push_item(owbm_pkg::t_op op, logic [7:0] d, logic line);
        if (gap_on && $urandom_range(0, 9) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.op         <= op;
        cmd_bus.data_byte  <= d;
        cmd_bus.line_level <= line;
        do @(posedge i_clk); while (!cmd_bus.ready);
        sb.take_item(op, d, line);
        @(negedge i_clk);
    endtask

    // Start a command and feed ticks until the sequencer is idle again.
    // refuse_odds != 0 sprinkles commands in while busy (1 in refuse_odds).
    task automatic run_command(owbm_pkg::t_op op, logic [7:0] d, int low_odds,
                               int refuse_odds);
        owbm_pkg::t_op extra;
        push_item(op, d, pick_line(low_odds));
        while (sb.busy()) begin
            extra = owbm_pkg::OP_TICK;
            if (refuse_odds != 0 && $urandom_range(1, refuse_odds) == 1) begin
                extra = owbm_pkg::t_op'($urandom_range(1, 3));
            end
            push_item(extra, 8'($urandom), pick_line(low_odds));
        end
    endtask

    task automatic put_reg(logic [owbm_pkg::CFG_IDX_W-1:0] idx, logic [owbm_pkg::CFG_W-1:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    // Registers change only with nothing in flight: stop sending, let every
    // expected beat come back, then let the pipe settle before writing.
    task automatic load_regs(logic [owbm_pkg::CFG_W-1:0] r0, logic [owbm_pkg::CFG_W-1:0] r1,
                             logic [owbm_pkg::CFG_W-1:0] r2, logic [owbm_pkg::CFG_W-1:0] r3,
                             logic [owbm_pkg::CFG_W-1:0] r4);
        cmd_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        put_reg(owbm_pkg::CFG_RESET_LOW, r0);
        put_reg(owbm_pkg::CFG_RELEASE_WAIT, r1);
        put_reg(owbm_pkg::CFG_PRESENCE_HOLD, r2);
        put_reg(owbm_pkg::CFG_WRITE_SLOT, r3);
        put_reg(owbm_pkg::CFG_READ_SLOT, r4);
        cfg_bus.valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int start_items;
        int low_odds;
        int refuse_odds;

        sb = new;
        sb.clear();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cycle_cnt          = 0;
        n_settings         = 1;
        gap_on             = 1'b0;
        stall_on           = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.op         = owbm_pkg::OP_TICK;
        cmd_bus.data_byte  = '0;
        cmd_bus.line_level = 1'b1;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = owbm_pkg::CFG_RESET_LOW;
        cfg_bus.data       = '0;
        res_bus.ready      = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Power-on lengths: bus reset and a byte write at the default timing.
        gap_on   = 1'b1;
        stall_on = 1'b1;
        run_command(owbm_pkg::OP_RESET, 8'h3C, 8, 0);
        run_command(owbm_pkg::OP_WRITE, 8'hA5, 2, 50);

        // Zero lengths must behave as one tick. Spare indexes must be ignored.
        load_regs('0, '0, '0, '0, '0);
        for (int k = SPARE_IDX_LO; k < (1 << owbm_pkg::CFG_IDX_W); k++) begin
            put_reg(owbm_pkg::CFG_IDX_W'(k), 16'hFFFF);
        end
        cfg_bus.valid <= 1'b0;
        @(negedge i_clk);

        gap_on   = 1'b0;
        stall_on = 1'b0;
        push_item(owbm_pkg::OP_TICK, 8'hFF, 1'b0);          // idle ticks, both levels
        push_item(owbm_pkg::OP_TICK, 8'h00, 1'b1);
        run_command(owbm_pkg::OP_WRITE, 8'h00, 2, 0);       // all-low and all-high bytes
        run_command(owbm_pkg::OP_WRITE, 8'hFF, 2, 0);
        run_command(owbm_pkg::OP_READ, 8'h00, 1, 0);        // line held low: reads 00
        run_command(owbm_pkg::OP_READ, 8'hFF, 0, 0);        // line released: reads FF
        run_command(owbm_pkg::OP_RESET, 8'h00, 1, 0);       // presence right away
        run_command(owbm_pkg::OP_RESET, 8'h81, 24, 0);      // long wait for presence
        gap_on   = 1'b1;
        stall_on = 1'b1;
        run_command(owbm_pkg::OP_WRITE, 8'h5A, 2, 2);       // commands while busy refused
        run_command(owbm_pkg::OP_READ, 8'h00, 2, 2);
        run_command(owbm_pkg::OP_RESET, 8'h00, 3, 2);

        load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_command(owbm_pkg::OP_RESET, 8'($urandom), 4, 0);
        run_command(owbm_pkg::OP_WRITE, 8'($urandom), 2, 0);
        run_command(owbm_pkg::OP_READ, 8'($urandom), 2, 0);

        load_regs(16'd3, 16'd2, 16'd4, 16'd5, 16'd2);
        run_command(owbm_pkg::OP_READ, 8'($urandom), 3, 8);
        run_command(owbm_pkg::OP_WRITE, 8'($urandom), 3, 8);
        run_command(owbm_pkg::OP_RESET, 8'($urandom), 5, 8);

        // Random rounds: fresh short lengths each round, idling switched per round
        // (the last round has none on either side).
        for (int rnd = 0; rnd < RAND_ROUNDS; rnd++) begin
            load_regs(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
            gap_on      = (rnd % 3 != 2) && (rnd != RAND_ROUNDS - 1);
            stall_on    = (rnd % 3 != 1) && (rnd != RAND_ROUNDS - 1);
            start_items = sb.n_items;
            while (sb.n_items - start_items < ROUND_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_item(owbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
                end else begin
                    low_odds = $urandom_range(1, 12);
                    case ($urandom_range(0, 2))
                        0:       refuse_odds = 0;
                        1:       refuse_odds = 6;
                        default: refuse_odds = 20;
                    endcase
                    run_command(owbm_pkg::t_op'($urandom_range(1, 3)), 8'($urandom),
                                low_odds, refuse_odds);
                end
            end
        end

        cmd_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d tick beats over %0d register settings (power-on, zero, one, short)",
                 sb.n_items, n_settings);
        $display("%0d commands started, %0d refused while busy, %0d completed, %0d mismatches",
                 sb.n_started, sb.n_refused, sb.n_done, sb.fails);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("PASS one_wire_bus_master_top");
        end else begin
            $display("FAIL one_wire_bus_master_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_ifs.sv
hw/rtl/owbm_front.sv
hw/rtl/owbm_queue.sv
hw/rtl/owbm_engine.sv
hw/rtl/one_wire_bus_master_top.sv
sim/one_wire_bus_master_top_tb.sv
